### sv/bsct_pkg.sv
// ----------------------------------------------------------------------------
// bsct_pkg
// Shared types and constants of the buddy size-class table.
// ----------------------------------------------------------------------------
package bsct_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int COF_WIDTH_DEF   = 32;

  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int SIZE_W     = 64;
  localparam int IDX_W      = 7;
  localparam int OCOF_W     = 32;
  localparam int LVL_W      = 7;
  localparam int ENT_W      = 8;
  localparam int DIV_CNT_W  = 7;

  localparam logic [CFG_W-1:0] ROOT_RST  = 32'd1024;
  localparam logic [CFG_W-1:0] ALIGN_RST = 32'd8;
  localparam logic [CFG_W-1:0] MIN_RST   = 32'd1;

  localparam logic [1:0] REG_ROOT  = 2'd0;
  localparam logic [1:0] REG_ALIGN = 2'd1;
  localparam logic [1:0] REG_MIN   = 2'd2;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] KIND_U = 2'd0;
  localparam logic [1:0] KIND_F = 2'd1;
  localparam logic [1:0] KIND_R = 2'd2;

  localparam logic [1:0] PAT_NONE = 2'd0;
  localparam logic [1:0] PAT_A1B3 = 2'd1;
  localparam logic [1:0] PAT_A3B1 = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LIN  = 12'b000000000010,
    S_BINL = 12'b000000000100,
    S_BINR = 12'b000000001000,
    S_DIV  = 12'b000000010000,
    S_RD0  = 12'b000000100000,
    S_CMP0 = 12'b000001000000,
    S_RD   = 12'b000010000000,
    S_CMP  = 12'b000100000000,
    S_FIN  = 12'b001000000000,
    S_RES  = 12'b010000000000,
    S_PUSH = 12'b100000000000
  } state_t;

endpackage

### sv/bsct_if.sv
// ----------------------------------------------------------------------------
// bsct_in_if / bsct_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface bsct_in_if;
  import bsct_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] req_bytes;
  modport source (output valid, mode, req_bytes, input ready);
  modport sink (input valid, mode, req_bytes, output ready);
endinterface

interface bsct_out_if;
  import bsct_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  block_index;
  logic [OCOF_W-1:0] coefficient;
  logic [LVL_W-1:0]  tree_level;
  logic [1:0]        buddy_kind;
  logic [1:0]        span_pattern;
  logic [1:0]        span_distance;
  logic              span_offset;
  logic              error;
  logic [ENT_W-1:0]  table_entries;
  logic [LVL_W-1:0]  buddy_levels;
  modport source (output valid, block_index, coefficient, tree_level, buddy_kind,
                  span_pattern, span_distance, span_offset, error, table_entries,
                  buddy_levels, input ready);
  modport sink (input valid, block_index, coefficient, tree_level, buddy_kind,
                span_pattern, span_distance, span_offset, error, table_entries,
                buddy_levels, output ready);
endinterface

### sv/buddy_size_class_table.sv
// ----------------------------------------------------------------------------
// buddy_size_class_table
// Size-class table of a buddy allocator with unequal splits: rebuild and
// best-fit query through one sequencer, one divide step and one table write and read port.
// ----------------------------------------------------------------------------
// Rebuild: writes the root and linear entries one at a time, then each binary
//   pair as a left and a right write; one table write port sets the pace.
// Query: the bit-serial divider rounds the size up to alignment units, then
//   each search step reads the table through the registered read port and
//   compares the entry with the units.
// One word at a time; a finished result waits in an output register.
// Synchronous active-low reset clears control state; no table is built.
// ----------------------------------------------------------------------------
module buddy_size_class_table #(
  parameter int TABLE_DEPTH = bsct_pkg::TABLE_DEPTH_DEF,
  parameter int COF_WIDTH   = bsct_pkg::COF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bsct_in_if.sink                       in_ch,
  bsct_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsct_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bsct_pkg::CFG_W-1:0]    pwdata,
  output logic [bsct_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);
  import bsct_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [COF_WIDTH-1:0] cof;
    logic [AW-1:0]        lvl;
    logic [1:0]           kind;
    logic [1:0]           pat;
    logic [1:0]           sdist;
    logic                 off;
  } ent_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [OCOF_W-1:0] cof;
    logic [LVL_W-1:0]  lvl;
    logic [1:0]        kind;
    logic [1:0]        pat;
    logic [1:0]        sdist;
    logic              off;
    logic              err;
  } res_t;

  // configuration
  logic [CFG_W-1:0] root_r, align_r, min_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= ROOT_RST;
      align_r <= ALIGN_RST;
      min_r   <= MIN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROOT:  root_r  <= pwdata;
        REG_ALIGN: align_r <= pwdata;
        REG_MIN:   min_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROOT:  prdata = root_r;
      REG_ALIGN: prdata = align_r;
      REG_MIN:   prdata = min_r;
      default:   prdata = '0;
    endcase
  end

  // table memory
  ent_t          mem [TABLE_DEPTH];
  ent_t          rd_q, wd;
  logic          we;
  logic [AW-1:0] wa, rd_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer state
  state_t                state_r, state_nxt;
  logic [COF_WIDTH-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt, lin_r, lin_nxt, lv_r, lv_nxt;
  logic                  a1b3_r, a1b3_nxt;
  logic [CNT_W-1:0]      tbl_r, tbl_nxt, blv_r, blv_nxt;
  logic [CFG_W-1:0]      halign_r, halign_nxt;
  logic [SIZE_W-1:0]     dvd_r, dvd_nxt, find_r, find_nxt;
  logic [CFG_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic signed [CNT_W:0] first_r, first_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt, step_r, step_nxt;
  logic [AW-1:0]         it_r, it_nxt;
  res_t                  res_r, res_nxt;
  logic                  ov_r, ov_nxt;
  res_t                  ob_r, ob_nxt;
  logic [CNT_W-1:0]      ot_r, ot_nxt, obl_r, obl_nxt;

  logic [COF_WIDTH-1:0]  n0, half_r, half_l;
  logic [CFG_W:0]        rem_sh, rem_sub;
  logic [CNT_W-1:0]      step_c;
  logic signed [CNT_W:0] it_c;
  logic                  first_pair;

  assign n0         = COF_WIDTH'(root_r);
  assign half_r     = n_r >> 1;
  assign half_l     = half_r + COF_WIDTH'(1);
  assign rem_sh     = {rem_r, dvd_r[SIZE_W-1]};
  assign rem_sub    = rem_sh - {1'b0, halign_r};
  assign step_c     = count_r >> 1;
  assign it_c       = first_r - $signed({1'b0, step_c});
  assign first_pair = (cnt_r == lin_r);

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    lin_nxt    = lin_r;
    lv_nxt     = lv_r;
    a1b3_nxt   = a1b3_r;
    tbl_nxt    = tbl_r;
    blv_nxt    = blv_r;
    halign_nxt = halign_r;
    dvd_nxt    = dvd_r;
    find_nxt   = find_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    it_nxt     = it_r;
    res_nxt    = res_r;
    we         = 1'b0;
    wa         = cnt_r[AW-1:0];
    wd         = '0;
    rd_addr    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          if (in_ch.mode == MODE_BUILD) begin
            we         = 1'b1;
            wa         = '0;
            wd         = '{cof: n0, lvl: '0, kind: KIND_U, pat: PAT_NONE,
                           sdist: 2'd0, off: 1'b0};
            n_nxt      = n0;
            cnt_nxt    = CNT_W'(1);
            a1b3_nxt   = 1'b0;
            halign_nxt = align_r;
            state_nxt  = S_LIN;
          end else if (tbl_r == '0 || halign_r == '0) begin
            res_nxt.err = 1'b1;
            state_nxt   = S_PUSH;
          end else begin
            dvd_nxt   = in_ch.req_bytes;
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_LIN: begin
        if (cnt_r < CNT_W'(TABLE_DEPTH) && !n_r[0] && 64'(n_r) > 64'(min_r)) begin
          we      = 1'b1;
          wd      = '{cof: half_r, lvl: cnt_r[AW-1:0], kind: KIND_U,
                      pat: PAT_NONE, sdist: 2'd1, off: 1'b0};
          n_nxt   = half_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          lin_nxt = cnt_r;
          lv_nxt  = cnt_r;
          if (n_r[0] && 64'(n_r) > 64'(min_r)) begin
            state_nxt = S_BINL;
          end else begin
            tbl_nxt   = cnt_r;
            blv_nxt   = cnt_r;
            state_nxt = S_PUSH;
          end
        end
      end
      S_BINL: begin
        if (64'(half_r) < 64'(min_r) ||
            ({1'b0, cnt_r} + (CNT_W+1)'(2)) > (CNT_W+1)'(TABLE_DEPTH)) begin
          tbl_nxt   = cnt_r;
          blv_nxt   = lv_r;
          state_nxt = S_PUSH;
        end else begin
          we = 1'b1;
          if (first_pair) begin
            wd = '{cof: half_l, lvl: lv_r[AW-1:0], kind: KIND_R, pat: PAT_A3B1,
                   sdist: 2'd1, off: 1'b0};
          end else if (a1b3_r) begin
            wd = '{cof: half_l, lvl: lv_r[AW-1:0], kind: KIND_R, pat: PAT_A1B3,
                   sdist: 2'd2, off: 1'b0};
          end else begin
            wd = '{cof: half_l, lvl: lv_r[AW-1:0], kind: KIND_F, pat: PAT_A3B1,
                   sdist: 2'd2, off: 1'b0};
          end
          state_nxt = S_BINR;
        end
      end
      S_BINR: begin
        we = 1'b1;
        wa = cnt_r[AW-1:0] + AW'(1);
        if (first_pair) begin
          wd = '{cof: half_r, lvl: lv_r[AW-1:0], kind: KIND_R, pat: PAT_A3B1,
                 sdist: 2'd2, off: 1'b1};
        end else if (a1b3_r) begin
          wd = '{cof: half_r, lvl: lv_r[AW-1:0], kind: KIND_F, pat: PAT_A1B3,
                 sdist: 2'd3, off: 1'b1};
        end else begin
          wd = '{cof: half_r, lvl: lv_r[AW-1:0], kind: KIND_R, pat: PAT_A3B1,
                 sdist: 2'd3, off: 1'b1};
        end
        a1b3_nxt  = half_l[0];
        n_nxt     = half_l[0] ? half_l : half_r;
        cnt_nxt   = cnt_r + CNT_W'(2);
        lv_nxt    = lv_r + CNT_W'(1);
        state_nxt = S_BINL;
      end
      S_DIV: begin
        if (!rem_sub[CFG_W]) begin
          rem_nxt = rem_sub[CFG_W-1:0];
          dvd_nxt = {dvd_r[SIZE_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CFG_W-1:0];
          dvd_nxt = {dvd_r[SIZE_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(SIZE_W - 1)) begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        rd_addr   = '0;
        find_nxt  = dvd_r + SIZE_W'(rem_r != '0);
        state_nxt = S_CMP0;
      end
      S_CMP0: begin
        if (find_r > 64'(rd_q.cof)) begin
          res_nxt.err = 1'b1;
          state_nxt   = S_PUSH;
        end else begin
          first_nxt = $signed({1'b0, tbl_r}) - (CNT_W+1)'(1);
          count_nxt = tbl_r;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (count_r == '0) begin
          if (first_r < 0) begin
            res_nxt.err = 1'b1;
            state_nxt   = S_PUSH;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          it_nxt    = (it_c < 0) ? '0 : it_c[AW-1:0];
          rd_addr   = (it_c < 0) ? '0 : it_c[AW-1:0];
          step_nxt  = step_c;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (64'(rd_q.cof) < find_r) begin
          first_nxt = $signed({1'b0, CNT_W'(it_r)}) - (CNT_W+1)'(1);
          count_nxt = count_r - step_r - CNT_W'(1);
        end else begin
          count_nxt = step_r;
        end
        state_nxt = S_RD;
      end
      S_FIN: begin
        rd_addr   = first_r[AW-1:0];
        state_nxt = S_RES;
      end
      S_RES: begin
        res_nxt.idx   = IDX_W'(first_r[AW-1:0]);
        res_nxt.cof   = OCOF_W'(rd_q.cof);
        res_nxt.lvl   = LVL_W'(rd_q.lvl);
        res_nxt.kind  = rd_q.kind;
        res_nxt.pat   = rd_q.pat;
        res_nxt.sdist = rd_q.sdist;
        res_nxt.off   = rd_q.off;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        if (!ov_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ot_nxt  = ot_r;
    obl_nxt = obl_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (state_r == S_PUSH && (!ov_r || out_ch.ready)) begin
      ov_nxt  = 1'b1;
      ob_nxt  = res_r;
      ot_nxt  = tbl_r;
      obl_nxt = blv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tbl_r    <= '0;
      blv_r    <= '0;
      halign_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tbl_r    <= tbl_nxt;
      blv_r    <= blv_nxt;
      halign_r <= halign_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    lin_r   <= lin_nxt;
    lv_r    <= lv_nxt;
    a1b3_r  <= a1b3_nxt;
    dvd_r   <= dvd_nxt;
    find_r  <= find_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    first_r <= first_nxt;
    count_r <= count_nxt;
    step_r  <= step_nxt;
    it_r    <= it_nxt;
    res_r   <= res_nxt;
    ob_r    <= ob_nxt;
    ot_r    <= ot_nxt;
    obl_r   <= obl_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.block_index   = ob_r.idx;
  assign out_ch.coefficient   = ob_r.cof;
  assign out_ch.tree_level    = ob_r.lvl;
  assign out_ch.buddy_kind    = ob_r.kind;
  assign out_ch.span_pattern  = ob_r.pat;
  assign out_ch.span_distance = ob_r.sdist;
  assign out_ch.span_offset   = ob_r.off;
  assign out_ch.error         = ob_r.err;
  assign out_ch.table_entries = (ot_r > CNT_W'(255)) ? 8'd255 : ENT_W'(ot_r);
  assign out_ch.buddy_levels  = LVL_W'(obl_r);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("word accepted while busy");
  a_tbl: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.block_index == '0 && out_ch.coefficient == '0)
    else $error("error result carries entry data");

endmodule

### sim/bsct_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsct_checker
// Watches both channels of the size-class table, predicts each result word
// from its own copy of the registers and the table, and counts mismatches.
// ----------------------------------------------------------------------------
module bsct_checker
  import bsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bsct_in_if          in_ch,
  bsct_out_if         out_ch,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_val,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [IDX_W-1:0]  block_index;
    logic [OCOF_W-1:0] coefficient;
    logic [LVL_W-1:0]  tree_level;
    logic [1:0]        buddy_kind;
    logic [1:0]        span_pattern;
    logic [1:0]        span_distance;
    logic              span_offset;
    logic              error;
    logic [ENT_W-1:0]  table_entries;
    logic [LVL_W-1:0]  buddy_levels;
  } answer_t;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic [31:0] root_reg, align_reg, min_reg, held_align;
  logic [31:0] cof_tab [DEPTH];
  int          lvl_tab [DEPTH];
  logic [1:0]  kind_tab [DEPTH];
  logic [1:0]  pat_tab [DEPTH];
  logic [1:0]  dist_tab [DEPTH];
  logic        off_tab [DEPTH];
  int          entry_count, level_count;
  answer_t     expected_answers[$];

  function automatic void store(int i, logic [31:0] c, int lv, logic [1:0] k,
                                logic [1:0] p, logic [1:0] d, logic o);
    if (i < DEPTH) begin
      cof_tab[i] = c;
      lvl_tab[i] = lv;
      kind_tab[i] = k;
      pat_tab[i] = p;
      dist_tab[i] = d;
      off_tab[i] = o;
    end
  endfunction

  function automatic void build_table();
    logic [32:0] n, l, r;
    int          cnt, lin, lv;
    bit          left_odd;
    n = {1'b0, root_reg};
    cnt = 1;
    left_odd = 1'b0;
    held_align = align_reg;
    store(0, n[31:0], 0, KIND_U, PAT_NONE, 2'd0, 1'b0);
    while (cnt < DEPTH && !n[0] && n > min_reg) begin
      n = n >> 1;
      store(cnt, n[31:0], cnt, KIND_U, PAT_NONE, 2'd1, 1'b0);
      cnt++;
    end
    lin = cnt;
    lv = cnt;
    if (n[0] && n > min_reg) begin
      forever begin
        r = n >> 1;
        l = r + 33'd1;
        if (r < min_reg || cnt + 2 > DEPTH) break;
        if (left_odd) begin
          store(cnt, l[31:0], lv, KIND_R, PAT_A1B3, 2'd2, 1'b0);
          store(cnt + 1, r[31:0], lv, KIND_F, PAT_A1B3, 2'd3, 1'b1);
        end else begin
          store(cnt, l[31:0], lv, KIND_F, PAT_A3B1, 2'd2, 1'b0);
          store(cnt + 1, r[31:0], lv, KIND_R, PAT_A3B1, 2'd3, 1'b1);
        end
        left_odd = l[0];
        n = left_odd ? l : r;
        cnt += 2;
        lv++;
      end
      if (cnt > lin) begin
        store(lin, cof_tab[lin], lvl_tab[lin], KIND_R, PAT_A3B1, 2'd1, 1'b0);
        store(lin + 1, cof_tab[lin + 1], lvl_tab[lin + 1], KIND_R, PAT_A3B1, 2'd2,
              1'b1);
      end
    end
    entry_count = cnt;
    level_count = lv;
  endfunction

  function automatic answer_t predict_answer(logic mode, logic [63:0] size);
    answer_t     a;
    logic [63:0] units;
    int          first, count, step, it;
    a = '0;
    if (mode == MODE_BUILD) begin
      build_table();
    end else if (entry_count == 0 || held_align == 0) begin
      a.error = 1'b1;
    end else begin
      units = size / held_align + ((size % held_align) != 0 ? 64'd1 : 64'd0);
      if (units > cof_tab[0]) begin
        a.error = 1'b1;
      end else begin
        first = entry_count - 1;
        count = entry_count;
        while (count > 0) begin
          step = count / 2;
          it = first - step;
          if (it < 0) it = 0;
          if (cof_tab[it] < units) begin
            first = it - 1;
            count -= step + 1;
          end else begin
            count = step;
          end
        end
        if (first < 0) begin
          a.error = 1'b1;
        end else begin
          a.block_index = first[IDX_W-1:0];
          a.coefficient = cof_tab[first];
          a.tree_level = lvl_tab[first][LVL_W-1:0];
          a.buddy_kind = kind_tab[first];
          a.span_pattern = pat_tab[first];
          a.span_distance = dist_tab[first];
          a.span_offset = off_tab[first];
        end
      end
    end
    a.table_entries = entry_count > 255 ? 8'd255 : entry_count[ENT_W-1:0];
    a.buddy_levels = level_count[LVL_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      root_reg = ROOT_RST;
      align_reg = ALIGN_RST;
      min_reg = MIN_RST;
      held_align = '0;
      entry_count = 0;
      level_count = 0;
      expected_answers.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ROOT: root_reg = cfg_val;
          REG_ALIGN: align_reg = cfg_val;
          REG_MIN: min_reg = cfg_val;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_answers.push_back(predict_answer(in_ch.mode, in_ch.req_bytes));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.block_index, out_ch.coefficient, out_ch.tree_level,
                out_ch.buddy_kind, out_ch.span_pattern, out_ch.span_distance,
                out_ch.span_offset, out_ch.error, out_ch.table_entries,
                out_ch.buddy_levels};
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
    end
    pending = expected_answers.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

### sim/buddy_size_class_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_size_class_table_tb
// Rebuilds the table under many register settings and fires best-fit
// queries with random idling on both sides; a checker scores each word.
// ----------------------------------------------------------------------------
module buddy_size_class_table_tb;
  import bsct_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  bit          calm = 1'b0;
  int          fail_count, pending;
  logic [31:0] cur_root = ROOT_RST, cur_align = ALIGN_RST;

  bsct_in_if  in_ch ();
  bsct_out_if out_ch ();

  buddy_size_class_table i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bsct_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr(psel && penable && pwrite && pready), .cfg_idx(paddr[3:2]),
    .cfg_val(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.req_bytes = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk)
    out_ch.ready <= calm || ($urandom_range(99) >= 11);

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROOT) cur_root = val;
    if (idx == REG_ALIGN) cur_align = val;
    @(posedge clk);
  endtask

  task automatic send_word(logic mode, logic [63:0] size);
    while (!calm && $urandom_range(99) < 11) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.req_bytes <= size;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_size();
    logic [63:0] top;
    top = {32'd0, cur_root} * {32'd0, cur_align};
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return top;
      2: return top + 1;
      3: return $urandom_range(16);
      default: return {$urandom, $urandom} % (top + 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_val(int lo);
    case ($urandom_range(5))
      0: return lo;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return $urandom_range(4096, lo);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(MODE_QUERY, 64'd5);
    send_word(MODE_BUILD, 0);
    send_word(MODE_QUERY, 0);
    send_word(MODE_QUERY, 1);
    send_word(MODE_QUERY, 8192);
    send_word(MODE_QUERY, 8193);
    send_word(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    write_reg(REG_ROOT, 32'hFFFF_FFFF);
    write_reg(REG_ALIGN, 32'hFFFF_FFFE);
    write_reg(REG_MIN, 32'd0);
    send_word(MODE_BUILD, 0);
    send_word(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(MODE_QUERY, 64'hFFFF_FFFD_0000_0002);
    send_word(MODE_QUERY, 3);
    drain();
    write_reg(REG_ROOT, 32'd0);
    write_reg(REG_ALIGN, 32'd3);
    write_reg(REG_MIN, 32'hFFFF_FFFF);
    send_word(MODE_BUILD, 0);
    send_word(MODE_QUERY, 0);
    send_word(MODE_QUERY, 1);
    drain();
    write_reg(REG_ROOT, 32'd96);
    write_reg(REG_ALIGN, 32'd2);
    write_reg(REG_MIN, 32'd1);
    send_word(MODE_BUILD, 0);
    send_word(MODE_QUERY, 5);
    send_word(MODE_QUERY, 192);
    for (int ph = 0; ph < 78; ph++) begin
      drain();
      calm = (ph >= 30 && ph < 38);
      write_reg(REG_ROOT, pick_val(1));
      write_reg(REG_ALIGN, pick_val(2) & 32'hFFFF_FFFE | ($urandom_range(9) == 0));
      write_reg(REG_MIN, ($urandom_range(9) == 0) ? 32'd0 :
                ($urandom_range(3) == 0) ? pick_val(1) : $urandom_range(8, 1));
      send_word(MODE_BUILD, 0);
      for (int k = 0; k < 20; k++)
        if ($urandom_range(29) == 0) send_word(MODE_BUILD, 0);
        else send_word(MODE_QUERY, pick_size());
    end
    calm = 1'b0;
    drain();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### buddy_size_class_table.f
sv/bsct_pkg.sv
sv/bsct_if.sv
sv/buddy_size_class_table.sv
sim/bsct_checker.sv
sim/buddy_size_class_table_tb.sv
